// ----- design/xss_pkg.sv -----
// Shared types, constants and the microcode table of the xorshift/sip stream cipher.
package xss_pkg;

   localparam int unsigned WORD_W     = 64;
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned INDEX_W    = 3;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned PTR_W      = 2;
   localparam int unsigned PC_W       = 5;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned NUM_WORDS  = 4;

   typedef logic [WORD_W-1:0] word_type;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INIT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DATA = 2'd2;

   // Mode register codes.
   localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RND   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ENC   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DEC   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_ENC;

   // Rotation and shift amounts.
   localparam int unsigned XS_ROTL  = 11;
   localparam int unsigned XS_ROTR  = 20;
   localparam int unsigned XS_SHR   = 5;
   localparam int unsigned SIP_ROT1 = 13;
   localparam int unsigned SIP_ROT3 = 16;
   localparam int unsigned SIP_ROT5 = 17;
   localparam int unsigned SIP_ROT7 = 21;
   localparam int unsigned SIP_ROTH = 32;

   // Loop counts, less one.
   localparam logic [CNT_W-1:0] XS_STEPS_M1   = 4'd15;
   localparam logic [CNT_W-1:0] SIP_ROUNDS_M1 = 4'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ALIGN,
      OP_LOAD,
      OP_XS_STEP,
      OP_MIX_IN,
      OP_SIP_A,
      OP_SIP_B,
      OP_MIX_OUT,
      OP_XS_OUT,
      OP_RND_OUT,
      OP_ENC,
      OP_DEC
   } uop_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_ALIGN,
      CND_LOOP,
      CND_PASS,
      CND_END
   } cond_type;

   typedef struct packed {
      uop_type          op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic [CNT_W-1:0] reload;
   } uword_type;

   // Microcode addresses.
   localparam logic [PC_W-1:0] PC_LOAD_ALIGN = 5'd0;
   localparam logic [PC_W-1:0] PC_LOAD_WR    = 5'd1;
   localparam logic [PC_W-1:0] PC_INIT_ALIGN = 5'd2;
   localparam logic [PC_W-1:0] PC_XS_LOOP    = 5'd3;
   localparam logic [PC_W-1:0] PC_MIX_IN     = 5'd4;
   localparam logic [PC_W-1:0] PC_SIP_LOOP   = 5'd5;
   localparam logic [PC_W-1:0] PC_SIP_LOOP_B = 5'd6;
   localparam logic [PC_W-1:0] PC_MIX_OUT    = 5'd7;
   localparam logic [PC_W-1:0] PC_RAW        = 5'd8;
   localparam logic [PC_W-1:0] PC_RND_A      = 5'd9;
   localparam logic [PC_W-1:0] PC_RND_B      = 5'd10;
   localparam logic [PC_W-1:0] PC_RND_OUT    = 5'd11;
   localparam logic [PC_W-1:0] PC_ENC_A      = 5'd12;
   localparam logic [PC_W-1:0] PC_ENC_B      = 5'd13;
   localparam logic [PC_W-1:0] PC_ENC_OUT    = 5'd14;
   localparam logic [PC_W-1:0] PC_DEC_A      = 5'd15;
   localparam logic [PC_W-1:0] PC_DEC_B      = 5'd16;
   localparam logic [PC_W-1:0] PC_DEC_OUT    = 5'd17;
   localparam logic [PC_W-1:0] PC_LAST       = PC_DEC_OUT;

   localparam logic [PC_W-1:0]  PC_NONE  = PC_LOAD_ALIGN;
   localparam logic [CNT_W-1:0] CNT_NONE = XS_STEPS_M1;

   function automatic word_type rotl64(input word_type x, input int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{OP_NOP, CND_END, PC_NONE, CNT_NONE};
      unique case (pc)
         PC_LOAD_ALIGN: w = '{OP_ALIGN,   CND_ALIGN, PC_NONE,     CNT_NONE};
         PC_LOAD_WR:    w = '{OP_LOAD,    CND_END,   PC_NONE,     CNT_NONE};
         PC_INIT_ALIGN: w = '{OP_ALIGN,   CND_ALIGN, PC_NONE,     CNT_NONE};
         PC_XS_LOOP:    w = '{OP_XS_STEP, CND_LOOP,  PC_XS_LOOP,  SIP_ROUNDS_M1};
         PC_MIX_IN:     w = '{OP_MIX_IN,  CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_SIP_LOOP:   w = '{OP_SIP_A,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_SIP_LOOP_B: w = '{OP_SIP_B,   CND_LOOP,  PC_SIP_LOOP, XS_STEPS_M1};
         PC_MIX_OUT:    w = '{OP_MIX_OUT, CND_PASS,  PC_XS_LOOP,  CNT_NONE};
         PC_RAW:        w = '{OP_XS_OUT,  CND_END,   PC_NONE,     CNT_NONE};
         PC_RND_A:      w = '{OP_SIP_A,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_RND_B:      w = '{OP_SIP_B,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_RND_OUT:    w = '{OP_RND_OUT, CND_END,   PC_NONE,     CNT_NONE};
         PC_ENC_A:      w = '{OP_SIP_A,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_ENC_B:      w = '{OP_SIP_B,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_ENC_OUT:    w = '{OP_ENC,     CND_END,   PC_NONE,     CNT_NONE};
         PC_DEC_A:      w = '{OP_SIP_A,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_DEC_B:      w = '{OP_SIP_B,   CND_NEXT,  PC_NONE,     CNT_NONE};
         PC_DEC_OUT:    w = '{OP_DEC,     CND_END,   PC_NONE,     CNT_NONE};
         default:       w = '{OP_NOP,     CND_END,   PC_NONE,     CNT_NONE};
      endcase
      return w;
   endfunction

endpackage

// ----- design/xss_req_if.sv -----
// Request channel of the stream cipher: valid/ready handshake with the request fields.
interface xss_req_if import xss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [INDEX_W-1:0]    word_index;
   logic [WORD_W-1:0]     data_word;

   modport source(output valid, output req_type, output word_index, output data_word,
                  input ready);
   modport sink(input valid, input req_type, input word_index, input data_word,
                output ready);
endinterface

// ----- design/xss_rsp_if.sv -----
// Result channel of the stream cipher: valid/ready handshake with the output word.
interface xss_rsp_if import xss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;

   modport source(output valid, output out_word, input ready);
   modport sink(input valid, input out_word, output ready);
endinterface

// ----- design/xorshift_sipround_stream_cipher.sv -----
// Xorshift/sip-round stream cipher driven by a microcoded sequencer.
// One item is worked on at a time; the request side is ready again the cycle after the
// microprogram ends. Load and init first run the align step, which walks the word pointer
// (0..3) back to zero one per cycle; then load writes the seed word and init runs two mixing
// passes. Data runs the output step alone (raw) or after one sip round in two halves (sip
// modes); the result sits in an output register and is held while stalled. Synchronous
// reset clears all state words, the word pointer, the sequencer and sets mode to encrypt.
module xorshift_sipround_stream_cipher import xss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   xss_req_if.sink           req_chan,
   xss_rsp_if.source         rsp_chan
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type          state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pass_ff, pass_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   word_type           data_ff, data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_word_ff, rsp_word_in;

   // The xorshift words are kept rotated so that entry 0 is always the word under the
   // pointer; every read is then at a fixed place.
   word_type xs_ff [NUM_WORDS];
   word_type xs_in [NUM_WORDS];
   word_type sip_ff [NUM_WORDS];
   word_type sip_in [NUM_WORDS];

   uword_type uword;
   logic      running, rsp_free, out_op, step_op, fire;
   word_type  s0, s1, xs_fb, step_sum;
   word_type  ha0, ha1, ha2, ha3, hb0, hb1, hb2, hb3;
   word_type  enc_sum, dec_diff;

   assign uword    = ucode_rom(pc_ff);
   assign running  = (state_ff == ST_RUN);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      out_op  = 1'b0;
      step_op = 1'b0;
      case (uword.op) inside
         OP_XS_OUT, OP_RND_OUT, OP_ENC, OP_DEC: begin
            out_op  = 1'b1;
            step_op = 1'b1;
         end
         OP_XS_STEP: step_op = 1'b1;
         default: ;
      endcase
   end

   assign fire = running && !(out_op && !rsp_free);

   // Xorshift step on the two leading words.
   assign s0       = xs_ff[0];
   assign s1       = xs_ff[1];
   assign xs_fb    = s1 ^ s0 ^ rotl64(s0, XS_ROTL) ^ rotl64(s0, WORD_W - XS_ROTR)
                     ^ (s1 >> XS_SHR);
   assign step_sum = s0 + s1;

   // First and second half of a sip round.
   assign ha0 = sip_ff[0] + sip_ff[1];
   assign ha2 = sip_ff[2] + sip_ff[3];
   assign ha1 = rotl64(sip_ff[1], SIP_ROT1) ^ ha0;
   assign ha3 = rotl64(sip_ff[3], SIP_ROT3) ^ ha2;
   assign hb2 = sip_ff[2] + sip_ff[1];
   assign hb0 = sip_ff[0] + sip_ff[3];
   assign hb1 = rotl64(sip_ff[1], SIP_ROT5) ^ hb2;
   assign hb3 = rotl64(sip_ff[3], SIP_ROT7) ^ hb0;

   assign enc_sum  = data_ff + sip_ff[0];
   assign dec_diff = data_ff - sip_ff[0];

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      ptr_in       = ptr_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      xs_in        = xs_ff;
      sip_in       = sip_ff;

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      if (state_ff == ST_IDLE) begin
         if (req_chan.valid) begin
            idx_in  = req_chan.word_index;
            data_in = req_chan.data_word;
            cnt_in  = XS_STEPS_M1;
            pass_in = 1'b0;
            unique case (req_chan.req_type)
               REQ_LOAD: begin
                  state_in = ST_RUN;
                  pc_in    = PC_LOAD_ALIGN;
               end
               REQ_INIT: begin
                  state_in = ST_RUN;
                  pc_in    = PC_INIT_ALIGN;
               end
               REQ_DATA: begin
                  state_in = ST_RUN;
                  unique case (mode_ff)
                     MODE_RAW: pc_in = PC_RAW;
                     MODE_RND: pc_in = PC_RND_A;
                     MODE_ENC: pc_in = PC_ENC_A;
                     MODE_DEC: pc_in = PC_DEC_A;
                     default:  pc_in = PC_RAW;
                  endcase
               end
               default: ;
            endcase
         end
      end else if (fire) begin
         // A step advances the pointer and shifts the words down by one.
         if (step_op) begin
            xs_in[0] = xs_fb;
            xs_in[1] = xs_ff[2];
            xs_in[2] = xs_ff[3];
            xs_in[3] = s0;
            ptr_in   = ptr_ff + 2'd1;
         end

         unique case (uword.op)
            OP_ALIGN: begin
               if (ptr_ff != '0) begin
                  xs_in[0] = xs_ff[3];
                  xs_in[1] = xs_ff[0];
                  xs_in[2] = xs_ff[1];
                  xs_in[3] = xs_ff[2];
                  ptr_in   = ptr_ff - 2'd1;
               end
            end
            OP_LOAD: begin
               if (idx_ff[INDEX_W-1]) begin
                  sip_in[idx_ff[PTR_W-1:0]] = data_ff;
               end else begin
                  xs_in[idx_ff[PTR_W-1:0]] = data_ff;
               end
            end
            OP_MIX_IN: begin
               for (int i = 0; i < NUM_WORDS; i++) begin
                  sip_in[i] = sip_ff[i] ^ xs_ff[i];
               end
            end
            OP_MIX_OUT: begin
               for (int i = 0; i < NUM_WORDS; i++) begin
                  xs_in[i] = xs_ff[i] ^ sip_ff[i];
               end
            end
            OP_SIP_A: begin
               sip_in[0] = rotl64(ha0, SIP_ROTH);
               sip_in[1] = ha1;
               sip_in[2] = ha2;
               sip_in[3] = ha3;
            end
            OP_SIP_B: begin
               sip_in[0] = hb0;
               sip_in[1] = hb1;
               sip_in[2] = rotl64(hb2, SIP_ROTH);
               sip_in[3] = hb3;
            end
            OP_XS_OUT: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = step_sum;
            end
            OP_RND_OUT: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = sip_ff[3];
               sip_in[3]    = sip_ff[3] ^ step_sum;
            end
            OP_ENC: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = enc_sum;
               sip_in[3]    = sip_ff[3] ^ data_ff;
               sip_in[0]    = sip_ff[0] ^ step_sum;
            end
            OP_DEC: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = dec_diff;
               sip_in[3]    = sip_ff[3] ^ dec_diff;
               sip_in[0]    = sip_ff[0] ^ step_sum;
            end
            default: ;
         endcase

         unique case (uword.cond)
            CND_NEXT: pc_in = pc_ff + 5'd1;
            CND_ALIGN: begin
               if (ptr_ff == '0) begin
                  pc_in = pc_ff + 5'd1;
               end
            end
            CND_LOOP: begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 4'd1;
                  pc_in  = uword.target;
               end else begin
                  cnt_in = uword.reload;
                  pc_in  = pc_ff + 5'd1;
               end
            end
            CND_PASS: begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  pc_in   = uword.target;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            CND_END:  state_in = ST_IDLE;
            default:  state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         ptr_ff       <= '0;
         mode_ff      <= MODE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            xs_ff[i]  <= '0;
            sip_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         ptr_ff       <= ptr_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         xs_ff        <= xs_in;
         sip_ff       <= sip_in;
      end
      idx_ff      <= idx_in;
      data_ff     <= data_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_word = rsp_word_ff;

   // A seed word is written only once the words are back in pointer-zero order.
   a_load_aligned: assert property (@(posedge clock) disable iff (reset)
      (running && uword.op == OP_LOAD) |-> (ptr_ff == '0))
      else $error("seed load with misaligned xorshift words");

   // Sixteen steps per pass bring the pointer back to zero before the mix-back.
   a_mix_aligned: assert property (@(posedge clock) disable iff (reset)
      (running && (uword.op == OP_MIX_IN || uword.op == OP_MIX_OUT)) |-> (ptr_ff == '0))
      else $error("init mix with nonzero word pointer");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (pc_ff <= PC_LAST))
      else $error("microcode address out of range");

   // A result appears only after an output step of the microprogram.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && out_op))
      else $error("result item without an output step");

endmodule

// ----- sim/xorshift_sipround_stream_cipher_tb.sv -----
// Self-checking testbench for the xorshift/sip-round stream cipher, directed then random.
module xorshift_sipround_stream_cipher_tb import xss_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 50;
   localparam int unsigned SETTLE       = 80;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned MAX_GAP      = 9;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam word_type    ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam word_type    TOP_BIT      = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic                  is_cfg;
      logic [REQ_TYPE_W-1:0] code;
      logic [INDEX_W-1:0]    idx;
      word_type              data;
      logic                  typed;
      word_type              typed_out;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;

   xss_req_if req_chan ();
   xss_rsp_if rsp_chan ();

   xorshift_sipround_stream_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Predicted cipher state.
   word_type          xs_word [NUM_WORDS];
   word_type          sip_word [NUM_WORDS];
   logic [PTR_W-1:0]  xs_ptr;
   logic [MODE_W-1:0] mode_now;

   word_type     words_due [$];
   stim_row_type directed_rows [$];

   int unsigned cycle_count = 0;
   int unsigned mismatches  = 0;
   int unsigned n_data, n_load, n_init, n_unused, n_checked, n_mode_writes;
   int unsigned burst_left = 0;
   bit          offering = 1'b0;
   bit          long_hold_req = 1'b0;
   word_type    want_word;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic word_type rot_left(input word_type x, input int unsigned n);
      logic [2*WORD_W-1:0] both;
      both = {x, x} << n;
      return both[2*WORD_W-1:WORD_W];
   endfunction

   function automatic word_type xs_advance();
      word_type s0, s1;
      s0 = xs_word[xs_ptr];
      xs_ptr = xs_ptr + 1'b1;
      s1 = xs_word[xs_ptr];
      xs_word[xs_ptr] = s1 ^ s0 ^ rot_left(s0, XS_ROTL) ^ rot_left(s0, WORD_W - XS_ROTR)
                        ^ (s1 >> XS_SHR);
      return s0 + s1;
   endfunction

   function automatic void sip_permute();
      sip_word[0] = sip_word[0] + sip_word[1];
      sip_word[2] = sip_word[2] + sip_word[3];
      sip_word[1] = rot_left(sip_word[1], SIP_ROT1) ^ sip_word[0];
      sip_word[3] = rot_left(sip_word[3], SIP_ROT3) ^ sip_word[2];
      sip_word[0] = rot_left(sip_word[0], SIP_ROTH);
      sip_word[2] = sip_word[2] + sip_word[1];
      sip_word[0] = sip_word[0] + sip_word[3];
      sip_word[1] = rot_left(sip_word[1], SIP_ROT5) ^ sip_word[2];
      sip_word[3] = rot_left(sip_word[3], SIP_ROT7) ^ sip_word[0];
      sip_word[2] = rot_left(sip_word[2], SIP_ROTH);
   endfunction

   function automatic void reseed_mix();
      word_type discard;
      xs_ptr = '0;
      repeat (2) begin
         repeat (16) discard = xs_advance();
         for (int i = 0; i < NUM_WORDS; i++) sip_word[i] = sip_word[i] ^ xs_word[i];
         repeat (4) sip_permute();
         for (int i = 0; i < NUM_WORDS; i++) xs_word[i] = xs_word[i] ^ sip_word[i];
      end
      xs_ptr = '0;
   endfunction

   // Applies one accepted request to the predicted state; returns 1 when it yields a word.
   function automatic bit step_cipher(input logic [REQ_TYPE_W-1:0] kind,
                                      input logic [INDEX_W-1:0] idx, input word_type data,
                                      output word_type result);
      result = '0;
      case (kind)
         REQ_LOAD: begin
            if (idx < NUM_WORDS) xs_word[idx[PTR_W-1:0]] = data;
            else sip_word[idx[PTR_W-1:0]] = data;
            xs_ptr = '0;
         end
         REQ_INIT: reseed_mix();
         REQ_DATA: begin
            case (mode_now)
               MODE_RAW: result = xs_advance();
               MODE_RND: begin
                  sip_permute();
                  result = sip_word[3];
                  sip_word[3] = sip_word[3] ^ xs_advance();
               end
               MODE_ENC: begin
                  sip_permute();
                  sip_word[3] = sip_word[3] ^ data;
                  result = data + sip_word[0];
                  sip_word[0] = sip_word[0] ^ xs_advance();
               end
               default: begin
                  sip_permute();
                  result = data - sip_word[0];
                  sip_word[3] = sip_word[3] ^ result;
                  sip_word[0] = sip_word[0] ^ xs_advance();
               end
            endcase
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic stim_row_type mk_row(input logic is_cfg,
                                           input logic [REQ_TYPE_W-1:0] code,
                                           input logic [INDEX_W-1:0] idx, input word_type data,
                                           input logic typed, input word_type typed_out);
      stim_row_type r;
      r.is_cfg    = is_cfg;
      r.code      = code;
      r.idx       = idx;
      r.data      = data;
      r.typed     = typed;
      r.typed_out = typed_out;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      mismatches++;
      $display("MISMATCH %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
   endtask

   task automatic release_channel();
      if (offering) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      release_channel();
      do @(posedge clock); while (words_due.size() != 0);
   endtask

   task automatic offer_request(input logic [REQ_TYPE_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                                input word_type data, input logic typed,
                                input word_type typed_out);
      word_type predicted;
      if (burst_left == 0) begin
         release_channel();
         repeat ($urandom_range(0, MAX_GAP)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.word_index <= idx;
      req_chan.data_word  <= data;
      offering = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      case (kind)
         REQ_LOAD: n_load++;
         REQ_INIT: n_init++;
         REQ_DATA: n_data++;
         default:  n_unused++;
      endcase
      if (step_cipher(kind, idx, data, predicted))
         words_due.push_back(typed ? typed_out : predicted);
   endtask

   // Mode changes only once the block has gone quiet; loads and inits give no result.
   task automatic write_mode(input logic [MODE_W-1:0] m);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_now = m;
      n_mode_writes++;
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return word_type'(1) << $urandom_range(0, WORD_W - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Result side: stall pattern of its own, plus a long hold-off on request.
   initial begin : result_sink
      int unsigned style, seg_len;
      rsp_chan.ready = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            @(posedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end
         style   = $urandom_range(0, 3);
         seg_len = $urandom_range(10, 60);
         repeat (seg_len) begin
            @(posedge clock);
            case (style)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (words_due.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_chan.out_word, '0);
         end else begin
            want_word = words_due.pop_front();
            n_checked++;
            if (rsp_chan.out_word !== want_word)
               report_mismatch("out_word", rsp_chan.out_word, want_word);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) @(posedge clock) cycle_count++;
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               words_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      int unsigned count, pick, start;
      logic [REQ_TYPE_W-1:0] kind;
      logic [MODE_W-1:0] m;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = '0;
      req_chan.word_index  = '0;
      req_chan.data_word   = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         xs_word[i]  = '0;
         sip_word[i] = '0;
      end
      xs_ptr   = '0;
      mode_now = MODE_RESET;

      // From reset the sip words are zero, so encryption passes the word through and
      // the all-zero xorshift words give zeros in raw mode.
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd0, ALL_ONES, 1'b1, ALL_ONES));
      directed_rows.push_back(mk_row(1'b0, REQ_UNUSED, 3'd7, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b1, MODE_RAW,   3'd0, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd0, '0, 1'b1, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd7, ALL_ONES, 1'b1, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd0, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd1, 64'd1, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd2, TOP_BIT, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd3, 64'h0123_4567_89AB_CDEF, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd4, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd5, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd6, 64'hDEAD_BEEF_F00D_CAFE, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_LOAD,   3'd7, 64'h5555_AAAA_5555_AAAA, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd2, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_INIT,   3'd3, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd5, TOP_BIT, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b1, MODE_RND,   3'd0, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd1, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd6, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b1, MODE_DEC,   3'd0, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd0, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd7, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b1, MODE_ENC,   3'd0, '0, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_DATA,   3'd4, TOP_BIT, 1'b0, '0));
      directed_rows.push_back(mk_row(1'b0, REQ_UNUSED, 3'd0, '0, 1'b0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) write_mode(row.code);
         else offer_request(row.code, row.idx, row.data, row.typed, row.typed_out);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       m = MODE_DEC;
            1:       m = MODE_RAW;
            2:       m = MODE_RND;
            3:       m = MODE_ENC;
            default: m = MODE_W'($urandom_range(0, 3));
         endcase
         write_mode(m);
         if (phase % 3 == 0) long_hold_req = 1'b1;
         count = 0;
         // Usually a full reseed first: all eight words loaded, then the mixing passes.
         if ($urandom_range(0, 3) != 0) begin
            start = $urandom_range(0, 7);
            for (int w = 0; w < 8; w++)
               offer_request(REQ_LOAD, INDEX_W'((start + w) % 8), random_word(), 1'b0, '0);
            offer_request(REQ_INIT, INDEX_W'($urandom_range(0, 7)), random_word(), 1'b0, '0);
            count += 9;
         end
         while (count < PHASE_ITEMS) begin
            if (count == PHASE_ITEMS / 2 && phase % 2 == 1) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 70)      kind = REQ_DATA;
            else if (pick < 84) kind = REQ_LOAD;
            else if (pick < 90) kind = REQ_INIT;
            else                kind = REQ_UNUSED;
            offer_request(kind, INDEX_W'($urandom_range(0, 7)), random_word(), 1'b0, '0);
            if (kind != REQ_UNUSED) count++;
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d requests: %0d data, %0d loads, %0d inits, %0d unused codes,",
               n_data + n_load + n_init + n_unused, n_data, n_load, n_init, n_unused);
      $display("%0d mode writes; compared %0d output words, %0d mismatches.",
               n_mode_writes, n_checked, mismatches);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- xorshift_sipround_stream_cipher.f -----
design/xss_pkg.sv
design/xss_req_if.sv
design/xss_rsp_if.sv
design/xorshift_sipround_stream_cipher.sv
sim/xorshift_sipround_stream_cipher_tb.sv
